### rtl/rau_pkg.sv
// Shared types and constants for the rational arithmetic unit.
`default_nettype none
package rau_pkg;

  parameter int OPERAND_WIDTH_DEF = 16;

  typedef enum logic [1:0] {
    REQ_ADD = 2'd0,
    REQ_SUB = 2'd1,
    REQ_MUL = 2'd2,
    REQ_DIV = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_DEN = 2'd1,
    ST_DIV_ZERO = 2'd2,
    ST_RSVD     = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_MUL0,
    DP_MUL1,
    DP_MUL2,
    DP_NORM,
    DP_DIV_GCD,
    DP_DIV_STEP,
    DP_GCD_NEXT,
    DP_DIV_NUM,
    DP_SAVE_NUM,
    DP_PUBLISH
  } dp_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL0,
    S_MUL1,
    S_MUL2,
    S_NORM,
    S_GCD_TEST,
    S_GCD_DIV,
    S_GCD_NEXT,
    S_NUM_DIV,
    S_NUM_SAVE,
    S_DEN_DIV,
    S_DONE
  } state_t;

  typedef struct packed {
    dp_op_t op;
  } rau_cmd_t;

  typedef struct packed {
    status_t err;
    logic    div_last;
    logic    b_zero;
  } rau_stat_t;

endpackage
`default_nettype wire

### rtl/rau_ctrl.sv
// Sequencer for the rational arithmetic unit.
`default_nettype none
module rau_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output rau_pkg::rau_cmd_t       cmd,
  input  wire rau_pkg::rau_stat_t stat
);
  import rau_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.op == DP_PUBLISH) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    cmd.op     = DP_NOP;
    in_ready   = (state == S_IDLE) && !rst;
    case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.op     = DP_LOAD;
          state_next = S_MUL0;
        end
      end
      S_MUL0: begin
        if (stat.err != ST_OK) begin
          state_next = S_DONE;
        end else begin
          cmd.op     = DP_MUL0;
          state_next = S_MUL1;
        end
      end
      S_MUL1: begin
        cmd.op     = DP_MUL1;
        state_next = S_MUL2;
      end
      S_MUL2: begin
        cmd.op     = DP_MUL2;
        state_next = S_NORM;
      end
      S_NORM: begin
        cmd.op     = DP_NORM;
        state_next = S_GCD_TEST;
      end
      S_GCD_TEST: begin
        if (stat.b_zero) begin
          cmd.op     = DP_DIV_NUM;
          state_next = S_NUM_DIV;
        end else begin
          cmd.op     = DP_DIV_GCD;
          state_next = S_GCD_DIV;
        end
      end
      S_GCD_DIV: begin
        cmd.op = DP_DIV_STEP;
        if (stat.div_last) state_next = S_GCD_NEXT;
      end
      S_GCD_NEXT: begin
        cmd.op     = DP_GCD_NEXT;
        state_next = S_GCD_TEST;
      end
      S_NUM_DIV: begin
        cmd.op = DP_DIV_STEP;
        if (stat.div_last) state_next = S_NUM_SAVE;
      end
      S_NUM_SAVE: begin
        cmd.op     = DP_SAVE_NUM;
        state_next = S_DEN_DIV;
      end
      S_DEN_DIV: begin
        cmd.op = DP_DIV_STEP;
        if (stat.div_last) state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.op     = DP_PUBLISH;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

`ifndef ASSERT_OFF
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_MUL0))
    else $error("accepted word did not start work");
  a_publish_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_DONE))
    else $error("result raised outside done state");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == DP_PUBLISH) |-> (!out_valid || out_ready))
    else $error("result overwritten while held");
`endif

endmodule
`default_nettype wire

### rtl/rau_dp.sv
// Datapath: shared multiplier, sign fix, shift-subtract divider, Euclid registers.
`default_nettype none
module rau_dp #(
  parameter int W = rau_pkg::OPERAND_WIDTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire rau_pkg::rau_cmd_t cmd,
  output rau_pkg::rau_stat_t     stat,
  input  wire logic [1:0]        in_type,
  input  wire logic [W-1:0]      in_n1,
  input  wire logic [W-1:0]      in_d1,
  input  wire logic [W-1:0]      in_n2,
  input  wire logic [W-1:0]      in_d2,
  output logic [2*W:0]           res_num,
  output logic [2*W-2:0]         res_den,
  output rau_pkg::status_t       res_status
);
  import rau_pkg::*;

  localparam int DW = 2 * W;
  localparam int CW = $clog2(DW + 1);

  req_t               req;
  status_t            err;
  logic signed [W-1:0] n1, d1, n2, d2;
  logic signed [DW-1:0] p0, p1, p2;
  logic               num_neg;
  logic [DW-1:0]      mag, den_abs, a, b, qn;
  logic [DW-1:0]      dq, dv, dr;
  logic [CW-1:0]      cnt;

  logic signed [W-1:0]  mx, my;
  logic signed [DW-1:0] prod;
  logic signed [DW:0]   sum, num_fix;
  logic signed [DW-1:0] den_s;
  logic [DW:0]          trial, trial_sub;
  status_t              err_new;

  always_comb begin
    mx = n1;
    my = d2;
    case (cmd.op)
      DP_MUL0: begin
        mx = n1;
        my = (req == REQ_MUL) ? n2 : d2;
      end
      DP_MUL1: begin
        mx = d1;
        my = n2;
      end
      DP_MUL2: begin
        mx = d1;
        my = d2;
      end
      default: begin
        mx = n1;
        my = d2;
      end
    endcase
    prod = mx * my;
  end

  always_comb begin
    case (req)
      REQ_ADD: sum = {p0[DW-1], p0} + {p1[DW-1], p1};
      REQ_SUB: sum = {p0[DW-1], p0} - {p1[DW-1], p1};
      default: sum = {p0[DW-1], p0};
    endcase
    den_s   = (req == REQ_DIV) ? p1 : p2;
    num_fix = den_s[DW-1] ? -sum : sum;
  end

  assign trial     = {dr, dq[DW-1]};
  assign trial_sub = trial - {1'b0, dv};

  always_comb begin
    if ((in_d1 == '0) || (in_d2 == '0)) begin
      err_new = ST_ZERO_DEN;
    end else if ((in_type == REQ_DIV) && (in_n2 == '0)) begin
      err_new = ST_DIV_ZERO;
    end else begin
      err_new = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      case (cmd.op)
        DP_LOAD: begin
          req <= req_t'(in_type);
          n1  <= in_n1;
          d1  <= in_d1;
          n2  <= in_n2;
          d2  <= in_d2;
          err <= err_new;
        end
        DP_MUL0: p0 <= prod;
        DP_MUL1: p1 <= prod;
        DP_MUL2: p2 <= prod;
        DP_NORM: begin
          num_neg <= num_fix[DW];
          mag     <= num_fix[DW] ? DW'(-num_fix) : num_fix[DW-1:0];
          den_abs <= den_s[DW-1] ? -den_s : den_s;
          a       <= num_fix[DW] ? DW'(-num_fix) : num_fix[DW-1:0];
          b       <= den_s[DW-1] ? -den_s : den_s;
        end
        DP_DIV_GCD: begin
          dq  <= a;
          dv  <= b;
          dr  <= '0;
          cnt <= CW'(DW);
        end
        DP_DIV_NUM: begin
          dq  <= mag;
          dv  <= a;
          dr  <= '0;
          cnt <= CW'(DW);
        end
        DP_SAVE_NUM: begin
          qn  <= dq;
          dq  <= den_abs;
          dv  <= a;
          dr  <= '0;
          cnt <= CW'(DW);
        end
        DP_DIV_STEP: begin
          // restoring step: one quotient bit per cycle
          if (!trial_sub[DW]) begin
            dr <= trial_sub[DW-1:0];
            dq <= {dq[DW-2:0], 1'b1};
          end else begin
            dr <= trial[DW-1:0];
            dq <= {dq[DW-2:0], 1'b0};
          end
          cnt <= cnt - 1'b1;
        end
        DP_GCD_NEXT: begin
          a <= b;
          b <= dr;
        end
        DP_PUBLISH: begin
          res_status <= err;
          if (err != ST_OK) begin
            res_num <= '0;
            res_den <= (DW-1)'(1);
          end else begin
            res_num <= num_neg ? -{1'b0, qn} : {1'b0, qn};
            res_den <= dq[DW-2:0];
          end
        end
        default: ;
      endcase
    end
  end

  assign stat.err      = err;
  assign stat.div_last = (cnt == CW'(1));
  assign stat.b_zero   = (b == '0);

endmodule
`default_nettype wire

### rtl/rational_arithmetic_unit_top.sv
// Top level of the rational arithmetic unit: stream ports, sequencer and datapath.
`default_nettype none
// Sequence: load, three multiplies and sign fix, then repeated Euclid remainder steps
//   (gcd test, shift-subtract division, operand swap), then the final gcd test,
//   two reductions by the gcd, the save step and publish.
// Error cases (zero denominator, division by zero) skip the multiplies and go to publish.
// Throughput: one word at a time; the shift-subtract divider sets the rate.
// The result register lets the next word be accepted while a result waits.
// Reset: synchronous, active high; clears sequencer state and output valid.
module rational_arithmetic_unit_top #(
  parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEF,
  localparam int TDW = ((4 * OPERAND_WIDTH + 7) / 8) * 8
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           s_tvalid,
  output logic                s_tready,
  // first_numerator, first_denominator, second_numerator, second_denominator
  input  wire logic [TDW-1:0] s_tdata,
  // req_type
  input  wire logic [1:0]     s_tuser,
  output logic                m_tvalid,
  input  wire logic           m_tready,
  // result_numerator, result_denominator, zero pad
  output logic [TDW-1:0]      m_tdata,
  // status
  output logic [1:0]          m_tuser
);
  import rau_pkg::*;

  localparam int W = OPERAND_WIDTH;

  rau_cmd_t         cmd;
  rau_stat_t        stat;
  logic [2*W:0]     res_num;
  logic [2*W-2:0]   res_den;
  status_t          res_status;

  // sequencer: owns the handshakes and steps the datapath
  rau_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // datapath: operand capture, products, gcd and reduction
  rau_dp #(.W(W)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_type    (s_tuser),
    .in_n1      (s_tdata[W-1:0]),
    .in_d1      (s_tdata[2*W-1:W]),
    .in_n2      (s_tdata[3*W-1:2*W]),
    .in_d2      (s_tdata[4*W-1:3*W]),
    .res_num    (res_num),
    .res_den    (res_den),
    .res_status (res_status)
  );

  // pack result fields, low bits first; pad upper bits with zero
  assign m_tdata = TDW'({res_den, res_num});
  assign m_tuser = res_status;

`ifndef ASSERT_OFF
  a_err_result: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser != ST_OK)) |-> (res_num == '0 && res_den == (2*W-1)'(1)))
    else $error("error result not 0/1");
  a_den_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (res_den != '0))
    else $error("zero result denominator");
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second word taken while busy");
`endif

endmodule
`default_nettype wire
